// ===== rtl/per_source_packet_limit_forwarder_assert.svh =====
// Assertion macros for the per-source packet limit forwarder
`ifndef PER_SOURCE_PACKET_LIMIT_FORWARDER_ASSERT_SVH
`define PER_SOURCE_PACKET_LIMIT_FORWARDER_ASSERT_SVH
// implication checked on every edge out of reset
`define PSLF_ASSERT(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("%m: check failed");
// implication with the consequent checked in the following cycle
`define PSLF_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("%m: check failed");
`endif

// ===== rtl/pslf_pkg.sv =====
// Types and constants for the per-source packet limit forwarder
`default_nettype none
package pslf_pkg;
  localparam int unsigned LimitEntriesDef = 1024;
  localparam int unsigned RouteEntriesDef = 16;
  localparam int unsigned CfgRegs = 4;

  typedef enum logic [1:0] {
    ACT_PACKET = 2'd0, ACT_LIMIT_WR = 2'd1, ACT_ROUTE_WR = 2'd2, ACT_NONE = 2'd3
  } action_e;
  typedef enum logic [1:0] {
    VERDICT_DROP = 2'd0, VERDICT_REDIRECT = 2'd1, VERDICT_WRITTEN = 2'd2, VERDICT_RSVD = 2'd3
  } verdict_e;
  typedef enum logic [2:0] {
    REASON_NONE = 3'd0, REASON_NOT_IPV4 = 3'd1, REASON_BAD_HEADER = 3'd2,
    REASON_NO_LIMIT = 3'd3, REASON_OVER_LIMIT = 3'd4, REASON_NO_ROUTE = 3'd5,
    REASON_BAD_PORT = 3'd6, REASON_RSVD = 3'd7
  } reason_e;

  localparam logic [1:0] CFG_PORT1 = 2'd0;
  localparam logic [1:0] CFG_PORT2 = 2'd1;
  localparam logic [1:0] CFG_PORT3 = 2'd2;
  localparam logic [1:0] CFG_UPLINK = 2'd3;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0] EthHeaderBytes = 16'd14;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] ingress_interface;
    logic [15:0] ether_type;
    logic [15:0] frame_length;
    logic [3:0]  header_words;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [31:0] entry_key;
    logic [31:0] entry_limit;
    logic [7:0]  entry_port;
    logic        entry_remove;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] out_interface;
    logic [2:0]  drop_reason;
    logic        write_status;
    logic [31:0] packet_count;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/per_source_packet_limit_forwarder.sv =====
// Top level: packet policing by source limit table and routing by destination table
//
// Usage: pulse start with an item on item_i while busy is low. The item is a
// packet header summary or a table write (add, update, remove). Exactly one
// result appears on result_o for one cycle with done_o high; the receiver
// cannot stall, so it must take every result. busy is low in the result
// cycle, so the next transfer may be accepted at the edge that takes it.
// One item is in work at a time. A non-uplink packet or a limit table write
// walks the limit memory (N = LIMIT_ENTRIES), one slot read per cycle; a
// packet found there then reads its slot and writes back the new count. An
// uplink packet or route table write walks the route table (R = ROUTE_ENTRIES).
// A header drop or unused action goes straight to the result.
// Reset clears registers, then a clearing pass over all N limit slots marks every
// slot free with busy high. Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) must be
// written only when idle, by the user; the block itself does not enforce it.
`default_nettype none
module per_source_packet_limit_forwarder
  import pslf_pkg::*;
#(
  parameter int unsigned LIMIT_ENTRIES = LimitEntriesDef,
  parameter int unsigned ROUTE_ENTRIES = RouteEntriesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  item_i,
  output logic           done_o,
  output out_item_t      result_o,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned LW = (LIMIT_ENTRIES > 1) ? $clog2(LIMIT_ENTRIES) : 1;
  localparam int unsigned RW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [LW-1:0] LLast = LW'(LIMIT_ENTRIES - 1);
  localparam logic [RW-1:0] RLast = RW'(ROUTE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LSCAN = 3'd1;
  localparam logic [2:0] S_LRD = 3'd2;
  localparam logic [2:0] S_LWB = 3'd3;
  localparam logic [2:0] S_RSCAN = 3'd4;
  localparam logic [2:0] S_RRD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] lim;
    logic [31:0] cnt;
  } lentry_t;

  logic [15:0] p1_q, p2_q, p3_q, up_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0; p2_q <= '0; p3_q <= '0; up_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PORT1: p1_q <= cfg_data_i;
        CFG_PORT2: p2_q <= cfg_data_i;
        CFG_PORT3: p3_q <= cfg_data_i;
        CFG_UPLINK: up_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // limit memory: valid, key, limit, count per slot
  lentry_t     lmem [LIMIT_ENTRIES];
  lentry_t     lrd_q;
  logic [31:0] route_key_q [ROUTE_ENTRIES];
  logic [7:0]  route_port_q [ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES-1:0] rvalid_q, rvalid_d;

  logic [2:0]    state_q, state_d;
  in_item_t      it_q;
  logic [LW-1:0] lidx_q, lidx_d;     // scan address issued
  logic          lissue_q, lissue_d;
  logic [LW-1:0] lchk_q;             // address of data now on read port
  logic          lchk_v_q;
  logic          lhit_q, lhit_d, lfree_v_q, lfree_v_d;
  logic [LW-1:0] lhit_idx_q, lhit_idx_d, lfree_idx_q, lfree_idx_d;
  logic [RW-1:0] ridx_q, ridx_d;
  logic          rend_q, rend_d;
  logic          rhit_q, rhit_d, rfree_v_q, rfree_v_d;
  logic [RW-1:0] rhit_idx_q, rhit_idx_d, rfree_idx_q, rfree_idx_d;
  out_item_t     res_q, res_d;
  logic          done_q, done_d;

  logic          lmem_we;
  logic [LW-1:0] lmem_wa;
  lentry_t       lmem_wd;
  logic [LW-1:0] lmem_ra;
  logic          rmem_we;

  always_ff @(posedge clk_i) begin
    if (lmem_we) lmem[lmem_wa] <= lmem_wd;
    lrd_q <= lmem[lmem_ra];
  end

  logic ip_bad_eth, ip_bad_hdr;
  logic [5:0] ip_bytes;
  logic [16:0] need_len;
  assign ip_bytes = {item_i.header_words, 2'b00};
  assign need_len = {1'b0, EthHeaderBytes} + 17'(ip_bytes);
  assign ip_bad_eth = (item_i.frame_length < EthHeaderBytes) ||
                      (item_i.ether_type != EtherTypeIpv4);
  assign ip_bad_hdr = (ip_bytes < 6'd20) || ({1'b0, item_i.frame_length} < need_len);

  logic [31:0] cnt_inc;
  assign cnt_inc = (lrd_q.cnt == 32'hFFFF_FFFF) ? lrd_q.cnt : lrd_q.cnt + 32'd1;

  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;

  logic [31:0] lkey_want;
  assign lkey_want = (it_q.action == ACT_PACKET) ? it_q.source_address : it_q.entry_key;
  logic l_hit_now, l_free_now, lscan_end;
  assign l_hit_now = lchk_v_q && lrd_q.valid && (lrd_q.key == lkey_want);
  assign l_free_now = lchk_v_q && !lrd_q.valid;
  assign lscan_end = !lissue_q && !lchk_v_q;
  logic [LW-1:0] lwr_slot;
  assign lwr_slot = lhit_q ? lhit_idx_q : lfree_idx_q;

  logic [RW-1:0] rsel;
  assign rsel = ridx_q;
  logic [31:0] rkey_want;
  assign rkey_want = (it_q.action == ACT_PACKET) ? it_q.destination_address : it_q.entry_key;
  logic r_hit_now, r_free_now;
  assign r_hit_now = rvalid_q[rsel] && (route_key_q[rsel] == rkey_want);
  assign r_free_now = !rvalid_q[rsel];
  logic [RW-1:0] rwr_slot;
  assign rwr_slot = rhit_q ? rhit_idx_q : rfree_idx_q;

  always_comb begin
    state_d = state_q;
    lidx_d = lidx_q;
    lissue_d = lissue_q;
    lhit_d = lhit_q;
    lhit_idx_d = lhit_idx_q;
    lfree_v_d = lfree_v_q;
    lfree_idx_d = lfree_idx_q;
    ridx_d = ridx_q;
    rend_d = rend_q;
    rhit_d = rhit_q;
    rhit_idx_d = rhit_idx_q;
    rfree_v_d = rfree_v_q;
    rfree_idx_d = rfree_idx_q;
    rvalid_d = rvalid_q;
    res_d = res_q;
    done_d = 1'b0;
    lmem_we = 1'b0;
    lmem_wa = lidx_q;
    lmem_wd = '0;
    lmem_ra = lidx_q;
    rmem_we = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        lmem_we = 1'b1;
        if (lidx_q == LLast) begin
          lidx_d = '0;
          state_d = S_IDLE;
        end else begin
          lidx_d = lidx_q + LW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          lidx_d = '0; lissue_d = 1'b1; lhit_d = 1'b0; lfree_v_d = 1'b0;
          ridx_d = '0; rend_d = 1'b0; rhit_d = 1'b0; rfree_v_d = 1'b0;
          res_d = '0;
          unique case (item_i.action)
            ACT_PACKET: begin
              if (ip_bad_eth) begin
                res_d.drop_reason = REASON_NOT_IPV4;
                state_d = S_DONE;
              end else if (ip_bad_hdr) begin
                res_d.drop_reason = REASON_BAD_HEADER;
                state_d = S_DONE;
              end else if (item_i.ingress_interface != up_q) begin
                state_d = S_LSCAN;
              end else begin
                state_d = S_RSCAN;
              end
            end
            ACT_LIMIT_WR: state_d = S_LSCAN;
            ACT_ROUTE_WR: state_d = S_RSCAN;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_LSCAN: begin
        // pipelined walk: address issued, data compared next cycle
        if (lissue_q) begin
          if (lidx_q == LLast) lissue_d = 1'b0;
          else lidx_d = lidx_q + LW'(1);
        end
        if (l_hit_now && !lhit_q) begin
          lhit_d = 1'b1;
          lhit_idx_d = lchk_q;
        end
        if (l_free_now && !lfree_v_q) begin
          lfree_v_d = 1'b1;
          lfree_idx_d = lchk_q;
        end
        if (lscan_end) begin
          if (it_q.action == ACT_PACKET) begin
            if (lhit_q) begin
              state_d = S_LRD;
            end else begin
              res_d.drop_reason = REASON_NO_LIMIT;
              state_d = S_DONE;
            end
          end else begin
            res_d.verdict = VERDICT_WRITTEN;
            state_d = S_DONE;
            if (it_q.entry_remove) begin
              lmem_we = lhit_q;
              lmem_wa = lhit_idx_q;
            end else if (lhit_q || lfree_v_q) begin
              lmem_we = 1'b1;
              lmem_wa = lwr_slot;
              lmem_wd.valid = 1'b1;
              lmem_wd.key = it_q.entry_key;
              lmem_wd.lim = it_q.entry_limit;
            end else begin
              res_d.write_status = 1'b1;
            end
          end
        end
      end
      S_LRD: begin
        lmem_ra = lhit_idx_q;
        state_d = S_LWB;
      end
      S_LWB: begin
        lmem_we = 1'b1;
        lmem_wa = lhit_idx_q;
        lmem_wd = lrd_q;
        lmem_wd.cnt = cnt_inc;
        res_d.packet_count = cnt_inc;
        if (cnt_inc > lrd_q.lim) begin
          res_d.drop_reason = REASON_OVER_LIMIT;
        end else begin
          res_d.verdict = VERDICT_REDIRECT;
          res_d.out_interface = up_q;
        end
        state_d = S_DONE;
      end
      S_RSCAN: begin
        if (!rend_q) begin
          if (r_hit_now && !rhit_q) begin
            rhit_d = 1'b1; rhit_idx_d = rsel;
          end
          if (r_free_now && !rfree_v_q) begin
            rfree_v_d = 1'b1; rfree_idx_d = rsel;
          end
          if (ridx_q == RLast) rend_d = 1'b1;
          else ridx_d = ridx_q + RW'(1);
        end else if (it_q.action == ACT_PACKET) begin
          state_d = S_RRD;
        end else begin
          res_d.verdict = VERDICT_WRITTEN;
          state_d = S_DONE;
          if (it_q.entry_remove) begin
            if (rhit_q) rvalid_d[rhit_idx_q] = 1'b0;
          end else if (rhit_q || rfree_v_q) begin
            rvalid_d[rwr_slot] = 1'b1;
            rmem_we = 1'b1;
          end else begin
            res_d.write_status = 1'b1;
          end
        end
      end
      S_RRD: begin
        state_d = S_DONE;
        if (!rhit_q) begin
          res_d.drop_reason = REASON_NO_ROUTE;
        end else begin
          unique case (route_port_q[rhit_idx_q])
            8'd1: begin res_d.verdict = VERDICT_REDIRECT; res_d.out_interface = p1_q; end
            8'd2: begin res_d.verdict = VERDICT_REDIRECT; res_d.out_interface = p2_q; end
            8'd3: begin res_d.verdict = VERDICT_REDIRECT; res_d.out_interface = p3_q; end
            default: res_d.drop_reason = REASON_BAD_PORT;
          endcase
        end
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q <= 1'b0;
      res_q <= '0;
      rvalid_q <= '0;
      lidx_q <= '0; lissue_q <= 1'b0; lchk_q <= '0; lchk_v_q <= 1'b0;
      lhit_q <= 1'b0; lhit_idx_q <= '0; lfree_v_q <= 1'b0; lfree_idx_q <= '0;
      ridx_q <= '0; rend_q <= 1'b0;
      rhit_q <= 1'b0; rhit_idx_q <= '0; rfree_v_q <= 1'b0; rfree_idx_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      res_q <= res_d;
      rvalid_q <= rvalid_d;
      lidx_q <= lidx_d; lissue_q <= lissue_d;
      lchk_q <= lidx_q;
      lchk_v_q <= (state_q == S_LSCAN) && lissue_q;
      lhit_q <= lhit_d; lhit_idx_q <= lhit_idx_d;
      lfree_v_q <= lfree_v_d; lfree_idx_q <= lfree_idx_d;
      ridx_q <= ridx_d; rend_q <= rend_d;
      rhit_q <= rhit_d; rhit_idx_q <= rhit_idx_d;
      rfree_v_q <= rfree_v_d; rfree_idx_q <= rfree_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rmem_we) begin
      route_key_q[rwr_slot] <= it_q.entry_key;
      route_port_q[rwr_slot] <= it_q.entry_port;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) it_q <= item_i;
  end

  `include "per_source_packet_limit_forwarder_assert.svh"
  `PSLF_ASSERT(a_done_idle, done_o, !busy)
  `PSLF_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `PSLF_ASSERT(a_redirect_reason, done_o && result_o.verdict == VERDICT_REDIRECT,
               result_o.drop_reason == REASON_NONE)
endmodule
`default_nettype wire

// ===== test/per_source_packet_limit_forwarder_tb.sv =====
// Testbench for the per-source packet limit forwarder: random and directed items, scoreboard checks
`default_nettype none
module per_source_packet_limit_forwarder_tb;
  import pslf_pkg::*;

  class forward_scoreboard;
    logic [15:0] port_if [CfgRegs];
    logic [31:0] limit_of [logic [31:0]];
    logic [31:0] count_of [logic [31:0]];
    logic [7:0]  port_of [logic [31:0]];
    out_item_t   pending [$];
    int          errors;

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      port_if[idx] = data;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t r;
      logic [15:0] uplink;
      logic [5:0] ip_bytes;
      logic [31:0] k;
      r = '0;
      uplink = port_if[CFG_UPLINK];
      ip_bytes = {it.header_words, 2'b00};
      k = it.entry_key;
      case (action_e'(it.action))
        ACT_LIMIT_WR: begin
          r.verdict = VERDICT_WRITTEN;
          if (it.entry_remove) begin
            if (limit_of.exists(k)) begin
              limit_of.delete(k);
              count_of.delete(k);
            end
          end else if (limit_of.exists(k) || limit_of.num() < LimitEntriesDef) begin
            limit_of[k] = it.entry_limit;
            count_of[k] = '0;
          end else r.write_status = 1'b1;
        end
        ACT_ROUTE_WR: begin
          r.verdict = VERDICT_WRITTEN;
          if (it.entry_remove) begin
            if (port_of.exists(k)) port_of.delete(k);
          end else if (port_of.exists(k) || port_of.num() < RouteEntriesDef) begin
            port_of[k] = it.entry_port;
          end else r.write_status = 1'b1;
        end
        ACT_PACKET: begin
          r.verdict = VERDICT_DROP;
          if (it.frame_length < EthHeaderBytes || it.ether_type != EtherTypeIpv4) begin
            r.drop_reason = REASON_NOT_IPV4;
          end else if (ip_bytes < 20 ||
                       {1'b0, it.frame_length} < 17'(EthHeaderBytes) + 17'(ip_bytes)) begin
            r.drop_reason = REASON_BAD_HEADER;
          end else if (it.ingress_interface != uplink) begin
            k = it.source_address;
            if (!limit_of.exists(k)) r.drop_reason = REASON_NO_LIMIT;
            else begin
              if (count_of[k] != 32'hFFFF_FFFF) count_of[k] = count_of[k] + 1;
              r.packet_count = count_of[k];
              if (count_of[k] > limit_of[k]) r.drop_reason = REASON_OVER_LIMIT;
              else begin
                r.verdict = VERDICT_REDIRECT;
                r.out_interface = uplink;
              end
            end
          end else begin
            k = it.destination_address;
            if (!port_of.exists(k)) r.drop_reason = REASON_NO_ROUTE;
            else if (port_of[k] >= 1 && port_of[k] <= 3) begin
              r.verdict = VERDICT_REDIRECT;
              r.out_interface = port_if[port_of[k] - 1];
            end else r.drop_reason = REASON_BAD_PORT;
          end
        end
        default: r = '0;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.verdict !== exp.verdict) begin
        $error("verdict exp %0d got %0d", exp.verdict, got.verdict);
        errors++;
      end
      if (got.out_interface !== exp.out_interface) begin
        $error("out_interface exp %0d got %0d", exp.out_interface, got.out_interface);
        errors++;
      end
      if (got.drop_reason !== exp.drop_reason) begin
        $error("drop_reason exp %0d got %0d", exp.drop_reason, got.drop_reason);
        errors++;
      end
      if (got.write_status !== exp.write_status) begin
        $error("write_status exp %0d got %0d", exp.write_status, got.write_status);
        errors++;
      end
      if (got.packet_count !== exp.packet_count) begin
        $error("packet_count exp %0d got %0d", exp.packet_count, got.packet_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    item_i;
  logic        done_o;
  out_item_t   result_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  forward_scoreboard sb;
  logic [31:0] key_pool [8];
  int idle_pct;
  int quiet_cycles;

  per_source_packet_limit_forwarder u_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t rand_bits();
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    start = 1'b1;
    item_i = it;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_transfer(it);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      item_i = rand_bits();
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic in_item_t good_packet(logic [15:0] ingress);
    in_item_t it;
    it = rand_bits();
    it.action = ACT_PACKET;
    it.ingress_interface = ingress;
    it.ether_type = EtherTypeIpv4;
    it.header_words = 4'($urandom_range(15, 5));
    it.frame_length = 16'(14 + 4 * it.header_words + $urandom_range(100));
    if ($urandom_range(9) == 0) it.frame_length = 16'($urandom_range(65535, 74));
    it.source_address = key_pool[$urandom_range(7)];
    it.destination_address = key_pool[$urandom_range(7)];
    return it;
  endfunction

  function automatic in_item_t table_write(action_e act, logic [31:0] k, logic [31:0] lim,
                                           logic [7:0] p, logic rm);
    in_item_t it;
    it = rand_bits();
    it.action = act;
    it.entry_key = k;
    it.entry_limit = lim;
    it.entry_port = p;
    it.entry_remove = rm;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    logic [15:0] up;
    up = sb.port_if[CFG_UPLINK];
    pick = $urandom_range(99);
    it = good_packet($urandom_range(1) ? up : 16'($urandom));
    if (pick < 8) begin
      it = rand_bits();
    end else if (pick < 14) begin
      it.header_words = 4'($urandom_range(15));
      it.frame_length = 16'($urandom_range(80));
    end else if (pick < 34) begin
      it = table_write(ACT_LIMIT_WR, key_pool[$urandom_range(7)],
                       $urandom_range(3) == 0 ? $urandom : $urandom_range(6), 8'($urandom),
                       $urandom_range(5) == 0);
    end else if (pick < 48) begin
      it = table_write(ACT_ROUTE_WR, key_pool[$urandom_range(7)], $urandom,
                       $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(4)),
                       $urandom_range(5) == 0);
    end else if (pick < 51) begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    logic [15:0] cfg_sets [4][4];
    sb = new();
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PORT1;
    cfg_data_i = '0;
    idle_pct = 20;
    for (int i = 0; i < CfgRegs; i++) sb.port_if[i] = '0;
    key_pool[0] = '0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset configuration
    send_item(table_write(ACT_LIMIT_WR, key_pool[0], 32'd1, 8'h00, 1'b0));
    send_item(table_write(ACT_LIMIT_WR, key_pool[1], 32'hFFFF_FFFF, 8'hFF, 1'b0));
    send_item(table_write(ACT_ROUTE_WR, key_pool[0], '0, 8'd1, 1'b0));
    send_item(table_write(ACT_ROUTE_WR, key_pool[1], '0, 8'd255, 1'b0));
    send_item(table_write(ACT_ROUTE_WR, key_pool[2], '0, 8'd0, 1'b0));
    it = good_packet(16'd1);
    it.frame_length = 16'd13;
    send_item(it);
    it = good_packet(16'd1);
    it.ether_type = 16'h86DD;
    send_item(it);
    it = good_packet(16'd1);
    it.header_words = 4'd4;
    send_item(it);
    it = good_packet(16'd1);
    it.header_words = 4'd15;
    it.frame_length = 16'd73;
    send_item(it);
    it = good_packet(16'd1);
    it.header_words = 4'd15;
    it.frame_length = 16'hFFFF;
    it.source_address = key_pool[0];
    send_item(it);
    send_item(it);
    send_item(it);
    it.source_address = key_pool[1];
    send_item(it);
    it.source_address = key_pool[5] ^ 32'h1;
    send_item(it);
    for (int i = 0; i < 3; i++) begin
      it = good_packet(16'd0);
      it.destination_address = key_pool[i];
      send_item(it);
    end
    it.destination_address = key_pool[5] ^ 32'h1;
    send_item(it);
    send_item(table_write(ACT_LIMIT_WR, key_pool[0], 32'd7, 8'h00, 1'b1));
    send_item(table_write(ACT_LIMIT_WR, key_pool[0], 32'd7, 8'h00, 1'b1));
    send_item(table_write(ACT_ROUTE_WR, key_pool[2], '0, 8'h00, 1'b1));
    it = '0;
    it.action = ACT_NONE;
    send_item(it);
    send_item(~it);

    cfg_sets[0] = '{16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF};
    cfg_sets[1] = '{16'h0000, 16'hFFFF, 16'h0002, 16'h0000};
    cfg_sets[2] = '{16'h1234, 16'h5678, 16'hFFFF, 16'h0004};
    cfg_sets[3] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int r = 0; r < CfgRegs; r++) write_reg(2'(r), cfg_sets[ph][r]);
      for (int n = 0; n < 90; n++) begin
        idle_pct = (ph == 1 && n < 60) ? 0 : 20;
        send_item(random_item());
      end
    end
    idle_pct = 20;

    // route table full and emptied
    for (int i = 0; i < RouteEntriesDef + 1; i++)
      send_item(table_write(ACT_ROUTE_WR, 32'h0A00_0000 + i, '0, 8'($urandom_range(4)), 1'b0));
    for (int i = 0; i < RouteEntriesDef + 1; i++)
      send_item(table_write(ACT_ROUTE_WR, 32'h0A00_0000 + i, '0, 8'h00, 1'b1));
    // limit table full
    for (int i = 0; i < LimitEntriesDef + 1; i++)
      send_item(table_write(ACT_LIMIT_WR, 32'hC000_0000 + i, 32'd2, 8'h00, 1'b0));
    it = good_packet(sb.port_if[CFG_UPLINK] ^ 16'h1);
    it.source_address = 32'hC000_0000 + LimitEntriesDef - 1;
    send_item(it);
    it.source_address = key_pool[6];
    send_item(it);

    drain();
    repeat (LimitEntriesDef + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== per_source_packet_limit_forwarder.f =====
+incdir+rtl
rtl/pslf_pkg.sv
rtl/per_source_packet_limit_forwarder.sv
test/per_source_packet_limit_forwarder_tb.sv
